@@ sv/sei_pkg.sv @@
// ----------------------------------------------------------------------------
// sei_pkg
// shared widths, register indexes, constants and fixed-point types of the scorer
// ----------------------------------------------------------------------------
`default_nettype none

package sei_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;
    localparam int ERR_W      = 32;
    localparam int SCORE_W    = 48;
    localparam int LINE_W     = 50;

    localparam logic [CFG_IDX_W-1:0] REG_F00_01  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_F02_10  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_F11_12  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_F20_21  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_F22     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_THRESH  = 3'd5;

    localparam logic [ERR_W-1:0]   ERR_SAT      = '1;
    localparam logic [SCORE_W-1:0] SCORE_MAX    = '1;
    localparam logic [16:0]        FRAC_ONE     = 17'h10000;
    localparam logic [31:0]        THRESH_RESET = 32'h0001_0000;

    typedef logic signed [31:0]       fix_t;
    typedef logic signed [LINE_W-1:0] line_t;

endpackage

`default_nettype wire

@@ sv/sei_ifs.sv @@
// ----------------------------------------------------------------------------
// sei_ifs
// valid/ready channels of the scorer: point pairs, results, register writes
// ----------------------------------------------------------------------------
`default_nettype none

interface sei_pt_if #(parameter int COORD_WIDTH = 32);
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] first_x;
    logic signed [COORD_WIDTH-1:0] first_y;
    logic signed [COORD_WIDTH-1:0] first_z;
    logic signed [COORD_WIDTH-1:0] second_x;
    logic signed [COORD_WIDTH-1:0] second_y;
    logic signed [COORD_WIDTH-1:0] second_z;
    logic                          start_of_set;

    modport source (output valid, first_x, first_y, first_z, second_x, second_y,
                    second_z, start_of_set, input ready);
    modport sink   (input valid, first_x, first_y, first_z, second_x, second_y,
                    second_z, start_of_set, output ready);
endinterface

interface sei_res_if import sei_pkg::*;;
    logic               valid;
    logic               ready;
    logic [ERR_W-1:0]   sampson_error;
    logic               is_inlier;
    logic [SCORE_W-1:0] score_so_far;

    modport source (output valid, sampson_error, is_inlier, score_so_far, input ready);
    modport sink   (input valid, sampson_error, is_inlier, score_so_far, output ready);
endinterface

interface sei_cfg_if import sei_pkg::*;;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

@@ sv/sampson_error_inlier_scorer.sv @@
// ----------------------------------------------------------------------------
// sampson_error_inlier_scorer
// sampson distance of one correspondence against F, inlier test, msac score
// ----------------------------------------------------------------------------
// sequence: a zero z, or l0, l1, m0 and m1 all zero, gives a saturated error for the test;
//   otherwise four 32-step normalizing divisions, ten line multiplies, up to 18
//   scaling shifts, six more multiplies, a 32-step root and the error division share
//   one divider, one root unit and one 32x32 multiplier; an inlier adds a score
//   division and multiply; one word at a time, the next taken once the result is registered
// reset: clears sequencer, output valid, score and registers; threshold is 1.0
`default_nettype none

module sampson_error_inlier_scorer import sei_pkg::*; #(
    parameter int COORD_WIDTH = 32
) (
    input  logic      clk,
    input  logic      rst_n,
    sei_pt_if.sink    pts,
    sei_res_if.source res,
    sei_cfg_if.sink   cfg
);

    localparam int DIV_W = (COORD_WIDTH > 32) ? COORD_WIDTH : 32;
    localparam int DVD_W = 66;

    localparam logic [4:0] S_IDLE    = 5'd0;
    localparam logic [4:0] S_NORM_LD = 5'd1;
    localparam logic [4:0] S_DIV     = 5'd2;
    localparam logic [4:0] S_NORM_WB = 5'd3;
    localparam logic [4:0] S_MUL     = 5'd4;
    localparam logic [4:0] S_ACC     = 5'd5;
    localparam logic [4:0] S_MAX     = 5'd6;
    localparam logic [4:0] S_SHIFT   = 5'd7;
    localparam logic [4:0] S_MUL2    = 5'd8;
    localparam logic [4:0] S_ACC2    = 5'd9;
    localparam logic [4:0] S_SQRT    = 5'd10;
    localparam logic [4:0] S_ERR_LD  = 5'd11;
    localparam logic [4:0] S_ERR_WB  = 5'd12;
    localparam logic [4:0] S_TEST    = 5'd13;
    localparam logic [4:0] S_SC_LD   = 5'd14;
    localparam logic [4:0] S_SQ_MUL  = 5'd15;
    localparam logic [4:0] S_SQ_WB   = 5'd16;
    localparam logic [4:0] S_DONE    = 5'd17;

    localparam logic [1:0] OP_NORM = 2'd0;
    localparam logic [1:0] OP_ERR  = 2'd1;
    localparam logic [1:0] OP_SC   = 2'd2;

    logic [4:0]  state_reg;
    logic [4:0]  cnt_reg;
    logic [3:0]  k_reg;
    logic [1:0]  op_reg;

    logic [63:0] f0001_reg, f0210_reg, f1112_reg, f2021_reg;
    logic [31:0] f22_reg, thr_reg;

    logic signed [COORD_WIDTH-1:0] x1_reg, y1_reg, z1_reg, x2_reg, y2_reg, z2_reg;

    fix_t        uv_reg [4];
    line_t       ln_reg [5];
    logic [LINE_W-1:0] mx_reg;
    line_t       num_reg;
    logic [63:0] d_reg, sv_reg, sres_reg, sbit_reg;

    logic [DIV_W-1:0] dr_reg, dd_reg;
    logic [31:0]      dl_reg, dq_reg;
    logic             dovf_reg;

    logic signed [63:0] prod_reg;
    logic [ERR_W-1:0]   err_reg;
    logic               inl_reg;
    logic [SCORE_W-1:0] score_reg;

    logic               ov_reg;
    logic [ERR_W-1:0]   oerr_reg;
    logic               oinl_reg;
    logic [SCORE_W-1:0] oscore_reg;

    // matrix entries as signed words
    fix_t f00, f01, f02, f10, f11, f12, f20, f21, f22;
    assign f00 = $signed(f0001_reg[31:0]);
    assign f01 = $signed(f0001_reg[63:32]);
    assign f02 = $signed(f0210_reg[31:0]);
    assign f10 = $signed(f0210_reg[63:32]);
    assign f11 = $signed(f1112_reg[31:0]);
    assign f12 = $signed(f1112_reg[63:32]);
    assign f20 = $signed(f2021_reg[31:0]);
    assign f21 = $signed(f2021_reg[63:32]);
    assign f22 = $signed(f22_reg);

    // shared multiplier operands
    fix_t               mul_a, mul_b, cval;
    logic signed [63:0] prod_next;
    logic [2:0]         lidx;
    line_t              prod_term;

    assign lidx      = k_reg[3:1];
    assign prod_term = LINE_W'(prod_reg >>> 16);
    assign prod_next = mul_a * mul_b;

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        if (state_reg == S_MUL2)
        begin
            case (k_reg)
                4'd0:    begin mul_a = uv_reg[2]; mul_b = $signed(ln_reg[0][31:0]); end
                4'd1:    begin mul_a = uv_reg[3]; mul_b = $signed(ln_reg[1][31:0]); end
                4'd2:    begin mul_a = $signed(ln_reg[0][31:0]); mul_b = mul_a; end
                4'd3:    begin mul_a = $signed(ln_reg[1][31:0]); mul_b = mul_a; end
                4'd4:    begin mul_a = $signed(ln_reg[3][31:0]); mul_b = mul_a; end
                4'd5:    begin mul_a = $signed(ln_reg[4][31:0]); mul_b = mul_a; end
                default: begin mul_a = '0; mul_b = '0; end
            endcase
        end
        else if (state_reg == S_SQ_MUL)
        begin
            mul_a = $signed(dq_reg);
            mul_b = $signed(dq_reg);
        end
        else
        begin
            // line products: l0 l1 l2 from the first point, m0 m1 from the second
            case (k_reg)
                4'd0:    begin mul_a = f00; mul_b = uv_reg[0]; end
                4'd1:    begin mul_a = f01; mul_b = uv_reg[1]; end
                4'd2:    begin mul_a = f10; mul_b = uv_reg[0]; end
                4'd3:    begin mul_a = f11; mul_b = uv_reg[1]; end
                4'd4:    begin mul_a = f20; mul_b = uv_reg[0]; end
                4'd5:    begin mul_a = f21; mul_b = uv_reg[1]; end
                4'd6:    begin mul_a = f00; mul_b = uv_reg[2]; end
                4'd7:    begin mul_a = f10; mul_b = uv_reg[3]; end
                4'd8:    begin mul_a = f01; mul_b = uv_reg[2]; end
                4'd9:    begin mul_a = f11; mul_b = uv_reg[3]; end
                default: begin mul_a = '0; mul_b = '0; end
            endcase
        end
    end

    always_comb
    begin
        case (lidx)
            3'd0:    cval = f02;
            3'd1:    cval = f12;
            3'd2:    cval = f22;
            3'd3:    cval = f20;
            3'd4:    cval = f21;
            default: cval = '0;
        endcase
    end

    // running max of line magnitudes
    line_t             mx_sel;
    logic [LINE_W-1:0] mx_mag;

    always_comb
    begin
        case (k_reg[1:0])
            2'd0:    mx_sel = ln_reg[0];
            2'd1:    mx_sel = ln_reg[1];
            2'd2:    mx_sel = ln_reg[3];
            default: mx_sel = ln_reg[4];
        endcase
        mx_mag = mx_sel[LINE_W-1] ? LINE_W'(-mx_sel) : LINE_W'(mx_sel);
    end

    // divider operand selection
    logic signed [COORD_WIDTH-1:0] a_sel, z_sel;
    logic [COORD_WIDTH-1:0]        a_mag, z_mag;
    logic [LINE_W-1:0]             num_mag;
    logic [DVD_W-1:0]              dvd, dvd_hi;
    logic [DIV_W-1:0]              dvs;
    logic                          div_load;

    always_comb
    begin
        case (k_reg[1:0])
            2'd0:    a_sel = x1_reg;
            2'd1:    a_sel = y1_reg;
            2'd2:    a_sel = x2_reg;
            default: a_sel = y2_reg;
        endcase
        z_sel   = k_reg[1] ? z2_reg : z1_reg;
        a_mag   = a_sel[COORD_WIDTH-1] ? (~a_sel + 1'b1) : a_sel;
        z_mag   = z_sel[COORD_WIDTH-1] ? (~z_sel + 1'b1) : z_sel;
        num_mag = num_reg[LINE_W-1] ? LINE_W'(-num_reg) : LINE_W'(num_reg);
        case (state_reg)
            S_ERR_LD:
            begin
                dvd = DVD_W'(num_mag) << 16;
                dvs = DIV_W'(sres_reg[31:0]);
            end
            S_SC_LD:
            begin
                dvd = DVD_W'(err_reg) << 16;
                dvs = DIV_W'(thr_reg);
            end
            default:
            begin
                dvd = DVD_W'(a_mag) << 16;
                dvs = DIV_W'(z_mag);
            end
        endcase
        dvd_hi   = dvd >> 32;
        div_load = (state_reg == S_NORM_LD) || (state_reg == S_ERR_LD) ||
                   (state_reg == S_SC_LD);
    end

    // one restoring step a cycle
    logic [DIV_W:0] dtr, ddif;
    logic           dqb;
    assign dtr  = {dr_reg, dl_reg[31]};
    assign ddif = dtr - {1'b0, dd_reg};
    assign dqb  = (dtr >= {1'b0, dd_reg});

    // square root step
    logic [63:0] sq_trial;
    logic        sq_ge;
    assign sq_trial = sres_reg + sbit_reg;
    assign sq_ge    = (sv_reg >= sq_trial);

    // normalized coordinate, truncated and saturated
    fix_t norm_val;
    logic norm_neg;
    always_comb
    begin
        norm_neg = a_sel[COORD_WIDTH-1] ^ z_sel[COORD_WIDTH-1];
        if (norm_neg)
            norm_val = (dovf_reg || (dq_reg > 32'h8000_0000)) ? $signed(32'h8000_0000)
                                                              : $signed(-dq_reg);
        else
            norm_val = (dovf_reg || dq_reg[31]) ? $signed(32'h7FFF_FFFF) : $signed(dq_reg);
    end

    logic [16:0]        sc_inc;
    logic [SCORE_W:0]   sc_sum;
    assign sc_inc = FRAC_ONE - prod_reg[32:16];
    assign sc_sum = {1'b0, score_reg} + (SCORE_W + 1)'(sc_inc);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            cnt_reg    <= '0;
            k_reg      <= '0;
            op_reg     <= OP_NORM;
            f0001_reg  <= '0;
            f0210_reg  <= '0;
            f1112_reg  <= '0;
            f2021_reg  <= '0;
            f22_reg    <= '0;
            thr_reg    <= THRESH_RESET;
            score_reg  <= '0;
            ov_reg     <= 1'b0;
        end
        else
        begin
            if (cfg.valid)
            begin
                unique case (cfg.index)
                    REG_F00_01: f0001_reg <= cfg.data;
                    REG_F02_10: f0210_reg <= cfg.data;
                    REG_F11_12: f1112_reg <= cfg.data;
                    REG_F20_21: f2021_reg <= cfg.data;
                    REG_F22:    f22_reg   <= cfg.data[31:0];
                    REG_THRESH: thr_reg   <= cfg.data[31:0];
                    default:    ;
                endcase
            end

            if (res.ready && state_reg != S_DONE)
                ov_reg <= 1'b0;

            if (div_load)
            begin
                dovf_reg <= (dvd_hi >= DVD_W'(dvs));
                dr_reg   <= DIV_W'(dvd_hi);
                dl_reg   <= dvd[31:0];
                dd_reg   <= dvs;
                dq_reg   <= '0;
                cnt_reg  <= '0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (pts.valid)
                    begin
                        x1_reg <= pts.first_x;
                        y1_reg <= pts.first_y;
                        z1_reg <= pts.first_z;
                        x2_reg <= pts.second_x;
                        y2_reg <= pts.second_y;
                        z2_reg <= pts.second_z;
                        if (pts.start_of_set)
                            score_reg <= '0;
                        k_reg <= '0;
                        if (pts.first_z == '0 || pts.second_z == '0)
                        begin
                            err_reg   <= ERR_SAT;
                            state_reg <= S_TEST;
                        end
                        else
                            state_reg <= S_NORM_LD;
                    end
                end
                S_NORM_LD:
                begin
                    op_reg    <= OP_NORM;
                    state_reg <= S_DIV;
                end
                S_DIV:
                begin
                    dr_reg  <= dqb ? ddif[DIV_W-1:0] : dtr[DIV_W-1:0];
                    dl_reg  <= dl_reg << 1;
                    dq_reg  <= {dq_reg[30:0], dqb};
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == 5'd31)
                    begin
                        case (op_reg)
                            OP_NORM: state_reg <= S_NORM_WB;
                            OP_ERR:  state_reg <= S_ERR_WB;
                            default: state_reg <= S_SQ_MUL;
                        endcase
                    end
                end
                S_NORM_WB:
                begin
                    uv_reg[k_reg[1:0]] <= norm_val;
                    if (k_reg == 4'd3)
                    begin
                        k_reg     <= '0;
                        state_reg <= S_MUL;
                    end
                    else
                    begin
                        k_reg     <= k_reg + 1'b1;
                        state_reg <= S_NORM_LD;
                    end
                end
                S_MUL:
                begin
                    prod_reg  <= prod_next;
                    state_reg <= S_ACC;
                end
                S_ACC:
                begin
                    // first product of a line seeds it with its constant term (f02, f12, f22, f20 or f21)
                    ln_reg[lidx] <= (k_reg[0] ? ln_reg[lidx] : LINE_W'(cval)) + prod_term;
                    if (k_reg == 4'd9)
                    begin
                        k_reg     <= '0;
                        mx_reg    <= '0;
                        state_reg <= S_MAX;
                    end
                    else
                    begin
                        k_reg     <= k_reg + 1'b1;
                        state_reg <= S_MUL;
                    end
                end
                S_MAX:
                begin
                    if (mx_mag > mx_reg)
                        mx_reg <= mx_mag;
                    if (k_reg == 4'd3)
                        state_reg <= S_SHIFT;
                    else
                        k_reg <= k_reg + 1'b1;
                end
                S_SHIFT:
                begin
                    if (mx_reg == '0)
                    begin
                        err_reg   <= ERR_SAT;
                        state_reg <= S_TEST;
                    end
                    else if (mx_reg[LINE_W-1:30] != '0)
                    begin
                        mx_reg <= mx_reg >> 1;
                        for (int i = 0; i < 5; i++)
                            ln_reg[i] <= ln_reg[i] >>> 1;
                    end
                    else
                    begin
                        num_reg   <= ln_reg[2];
                        d_reg     <= '0;
                        k_reg     <= '0;
                        state_reg <= S_MUL2;
                    end
                end
                S_MUL2:
                begin
                    prod_reg  <= prod_next;
                    state_reg <= S_ACC2;
                end
                S_ACC2:
                begin
                    if (k_reg < 4'd2)
                        num_reg <= num_reg + prod_term;
                    else
                        d_reg <= d_reg + 64'(prod_reg);
                    if (k_reg == 4'd5)
                    begin
                        sv_reg    <= d_reg + 64'(prod_reg);
                        sres_reg  <= '0;
                        sbit_reg  <= 64'h4000_0000_0000_0000;
                        cnt_reg   <= '0;
                        state_reg <= S_SQRT;
                    end
                    else
                    begin
                        k_reg     <= k_reg + 1'b1;
                        state_reg <= S_MUL2;
                    end
                end
                S_SQRT:
                begin
                    if (sq_ge)
                    begin
                        sv_reg   <= sv_reg - sq_trial;
                        sres_reg <= (sres_reg >> 1) + sbit_reg;
                    end
                    else
                        sres_reg <= sres_reg >> 1;
                    sbit_reg <= sbit_reg >> 2;
                    cnt_reg  <= cnt_reg + 1'b1;
                    if (cnt_reg == 5'd31)
                        state_reg <= S_ERR_LD;
                end
                S_ERR_LD:
                begin
                    op_reg    <= OP_ERR;
                    state_reg <= S_DIV;
                end
                S_ERR_WB:
                begin
                    err_reg   <= dovf_reg ? ERR_SAT : dq_reg;
                    state_reg <= S_TEST;
                end
                S_TEST:
                begin
                    inl_reg <= (err_reg < thr_reg);
                    if (err_reg < thr_reg)
                        state_reg <= S_SC_LD;
                    else
                        state_reg <= S_DONE;
                end
                S_SC_LD:
                begin
                    op_reg    <= OP_SC;
                    state_reg <= S_DIV;
                end
                S_SQ_MUL:
                begin
                    prod_reg  <= prod_next;
                    state_reg <= S_SQ_WB;
                end
                S_SQ_WB:
                begin
                    score_reg <= sc_sum[SCORE_W] ? SCORE_MAX : sc_sum[SCORE_W-1:0];
                    state_reg <= S_DONE;
                end
                S_DONE:
                begin
                    if (!ov_reg || res.ready)
                    begin
                        ov_reg     <= 1'b1;
                        oerr_reg   <= err_reg;
                        oinl_reg   <= inl_reg;
                        oscore_reg <= score_reg;
                        state_reg  <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign pts.ready         = (state_reg == S_IDLE);
    assign cfg.ready         = 1'b1;
    assign res.valid         = ov_reg;
    assign res.sampson_error = oerr_reg;
    assign res.is_inlier     = oinl_reg;
    assign res.score_so_far  = oscore_reg;

    a_inlier_not_sat: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid && res.is_inlier |-> res.sampson_error != ERR_SAT)
        else $error("inlier reported with saturated error");

    a_scaled_lines: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_MUL2 |-> mx_reg[LINE_W-1:30] == '0)
        else $error("line scaling left a value at or above 2^30");

    a_root_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_ERR_LD |-> sres_reg[63:31] == '0)
        else $error("square root exceeds 31 bits");

    a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        pts.valid && pts.ready |=> state_reg != S_IDLE)
        else $error("sequencer did not start on an accepted word");

endmodule

`default_nettype wire

@@ dv/sampson_error_inlier_scorer_tb.sv @@
// ----------------------------------------------------------------------------
// sampson_error_inlier_scorer_tb
// drives point pairs through the sampson scorer under random source and sink
// gaps and compares every result word with a bit-exact fixed-point predictor
// ----------------------------------------------------------------------------
`default_nettype none

module sampson_error_inlier_scorer_tb import sei_pkg::*;;

    timeunit 1ns;
    timeprecision 1ps;

    // index outside the register file, writes to it are dropped
    localparam logic [CFG_IDX_W-1:0] REG_NONE = 3'd7;

    typedef struct packed {
        logic [31:0] fx, fy, fz, sx, sy, sz;
        logic        sos;
    } pair_t;

    typedef struct packed {
        logic [ERR_W-1:0]   err;
        logic               inl;
        logic [SCORE_W-1:0] score;
    } score_word_t;

    logic clk;
    logic rst_n;

    sei_pt_if  #(.COORD_WIDTH(32)) pts ();
    sei_res_if res ();
    sei_cfg_if cfg ();

    sampson_error_inlier_scorer #(.COORD_WIDTH(32)) uut (
        .clk   (clk),
        .rst_n (rst_n),
        .pts   (pts),
        .res   (res),
        .cfg   (cfg)
    );

    // predictor state
    logic [63:0]        fm_reg [0:3];
    logic [31:0]        f22_reg;
    logic [31:0]        thresh_reg;
    logic [SCORE_W-1:0] score_acc;

    pair_t       pair_q [$];
    score_word_t expected_q [$];
    int          err_count;
    int          src_idle_pct;
    int          snk_idle_pct;
    int          hold_cycles;
    logic        in_taken;

    function automatic void add_pair(pair_t p);
        pair_q = {pair_q, p};
    endfunction

    function automatic void add_expected(score_word_t w);
        expected_q = {expected_q, w};
    endfunction

    function automatic longint fl_shift(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint magn(longint v);
        return v < 0 ? -v : v;
    endfunction

    function automatic longint norm_coord(longint a, longint z);
        longint q;
        q = (magn(a) << 16) / magn(z);
        if ((a < 0) != (z < 0))
        begin
            if (q > 64'h8000_0000)
                q = 64'h8000_0000;
            return -q;
        end
        if (q > 64'h7FFF_FFFF)
            q = 64'h7FFF_FFFF;
        return q;
    endfunction

    function automatic longint line_dot(longint a, longint b, longint c, longint p,
                                        longint q);
        return fl_shift(a * p, 16) + fl_shift(b * q, 16) + c;
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v)
            b = b >> 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic longint unsigned sampson_dist(pair_t p);
        longint f [0:8];
        longint u1, v1, u2, v2, l0, l1, l2, m0, m1, num;
        longint unsigned mx, d, r, an;
        int s;
        if (p.fz == 0 || p.sz == 0)
            return 64'hFFFF_FFFF;
        for (int i = 0; i < 4; i++)
        begin
            f[2*i]   = longint'($signed(fm_reg[i][31:0]));
            f[2*i+1] = longint'($signed(fm_reg[i][63:32]));
        end
        f[8] = longint'($signed(f22_reg));
        u1 = norm_coord($signed(p.fx), $signed(p.fz));
        v1 = norm_coord($signed(p.fy), $signed(p.fz));
        u2 = norm_coord($signed(p.sx), $signed(p.sz));
        v2 = norm_coord($signed(p.sy), $signed(p.sz));
        l0 = line_dot(f[0], f[1], f[2], u1, v1);
        l1 = line_dot(f[3], f[4], f[5], u1, v1);
        l2 = line_dot(f[6], f[7], f[8], u1, v1);
        m0 = line_dot(f[0], f[3], f[6], u2, v2);
        m1 = line_dot(f[1], f[4], f[7], u2, v2);
        mx = magn(l0);
        if (magn(l1) > mx) mx = magn(l1);
        if (magn(m0) > mx) mx = magn(m0);
        if (magn(m1) > mx) mx = magn(m1);
        if (mx == 0)
            return 64'hFFFF_FFFF;
        s = 0;
        while ((mx >> s) >= (64'd1 << 30))
            s++;
        l0 = fl_shift(l0, s); l1 = fl_shift(l1, s); l2 = fl_shift(l2, s);
        m0 = fl_shift(m0, s); m1 = fl_shift(m1, s);
        num = fl_shift(u2 * l0, 16) + fl_shift(v2 * l1, 16) + l2;
        d = l0 * l0 + l1 * l1 + m0 * m0 + m1 * m1;
        r = int_sqrt(d);
        if (r == 0)
            return 64'hFFFF_FFFF;
        an = magn(num);
        if (an >= (r << 16))
            return 64'hFFFF_FFFF;
        return (an << 16) / r;
    endfunction

    function automatic score_word_t predict_score(pair_t p);
        score_word_t w;
        longint unsigned e, q, inc, acc;
        if (p.sos)
            score_acc = '0;
        e = sampson_dist(p);
        w.inl = 1'b0;
        if (e < thresh_reg)
        begin
            q   = (e << 16) / thresh_reg;
            inc = 65536 - ((q * q) >> 16);
            acc = score_acc + inc;
            if (acc > SCORE_MAX)
                acc = SCORE_MAX;
            score_acc = acc[SCORE_W-1:0];
            w.inl = 1'b1;
        end
        w.err   = e[31:0];
        w.score = score_acc;
        return w;
    endfunction

    task automatic report_mismatch(string what, longint unsigned got, longint unsigned exp_v);
        $display("mismatch %s: got %h expected %h at %0t", what, got, exp_v, $realtime);
        err_count++;
    endtask

    // ---------------- clock, reset, limit ----------------
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #400ms;
        $display("Test completed with failures");
        $finish;
    end

    // ---------------- driver ----------------
    // input word taken at the last rising edge
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_taken <= 1'b0;
        else
            in_taken <= pts.valid && pts.ready;
    end

    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pts.valid <= 1'b0;
        end
        else
        begin
            if (in_taken)
                add_expected(predict_score(pair_q.pop_front()));
            if (!pts.valid || in_taken)
            begin
                if (pair_q.size() > 0 && $urandom_range(99, 0) >= src_idle_pct)
                begin
                    pts.valid        <= 1'b1;
                    pts.first_x      <= pair_q[0].fx;
                    pts.first_y      <= pair_q[0].fy;
                    pts.first_z      <= pair_q[0].fz;
                    pts.second_x     <= pair_q[0].sx;
                    pts.second_y     <= pair_q[0].sy;
                    pts.second_z     <= pair_q[0].sz;
                    pts.start_of_set <= pair_q[0].sos;
                end
                else
                    pts.valid <= 1'b0;
            end
        end
    end

    // ready: random idling, or a long hold-off when requested
    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res.ready <= 1'b0;
        else if (hold_cycles > 0)
        begin
            hold_cycles <= hold_cycles - 1;
            res.ready   <= 1'b0;
        end
        else
            res.ready <= ($urandom_range(99, 0) >= snk_idle_pct);
    end

    // ---------------- monitor ----------------
    always @(posedge clk)
    begin
        score_word_t exp_w;
        if (rst_n && res.valid && res.ready)
        begin
            if (expected_q.size() == 0)
                report_mismatch("unexpected word", res.sampson_error, 0);
            else
            begin
                exp_w = expected_q.pop_front();
                if (res.sampson_error !== exp_w.err)
                    report_mismatch("sampson_error", res.sampson_error, exp_w.err);
                if (res.is_inlier !== exp_w.inl)
                    report_mismatch("is_inlier", res.is_inlier, exp_w.inl);
                if (res.score_so_far !== exp_w.score)
                    report_mismatch("score_so_far", res.score_so_far, exp_w.score);
            end
        end
    end

    // ---------------- stimulus ----------------
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [63:0] val);
        @(negedge clk);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data  <= val;
        @(posedge clk);
        while (!cfg.ready)
            @(posedge clk);
        case (idx)
            REG_F00_01: fm_reg[0] = val;
            REG_F02_10: fm_reg[1] = val;
            REG_F11_12: fm_reg[2] = val;
            REG_F20_21: fm_reg[3] = val;
            REG_F22:    f22_reg = val[31:0];
            REG_THRESH: thresh_reg = val[31:0];
            default: ;
        endcase
        @(negedge clk);
        cfg.valid <= 1'b0;
    endtask

    task automatic drain_all();
        while (pair_q.size() > 0 || pts.valid || expected_q.size() > 0)
            @(posedge clk);
        repeat (400) @(posedge clk);
    endtask

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(5, 0))
            0: return $urandom();
            1: return 32'($signed($urandom_range(4194304, 0)) - 2097152);
            2: return 32'h8000_0000 | $urandom_range(1, 0);
            3: return 32'h7FFF_FFFF - $urandom_range(1, 0);
            default: return 32'($signed($urandom_range(65536 * 64, 0)) - 65536 * 32);
        endcase
    endfunction

    function automatic logic [31:0] rand_z();
        case ($urandom_range(9, 0))
            0: return 32'd0;
            1: return $urandom();
            2: return 32'($signed($urandom_range(200, 0)) - 100);
            default: return $urandom_range(1, 0) ? 32'h0001_0000 : 32'hFFFF_0000;
        endcase
    endfunction

    function automatic logic [31:0] rand_f();
        case ($urandom_range(3, 0))
            0: return $urandom();
            1: return $urandom_range(1, 0) ? 32'h7FFF_FFFF : 32'h8000_0000;
            default: return 32'($signed($urandom_range(1 << 24, 0)) - (1 << 23));
        endcase
    endfunction

    function automatic pair_t rand_pair(int set_len_pos);
        pair_t p;
        p.fx = rand_coord(); p.fy = rand_coord(); p.fz = rand_z();
        p.sx = rand_coord(); p.sy = rand_coord(); p.sz = rand_z();
        p.sos = (set_len_pos == 0) || ($urandom_range(49, 0) == 0);
        return p;
    endfunction

    task automatic random_setting(bit extreme);
        for (int i = 0; i < 4; i++)
            write_reg(REG_F00_01 + CFG_IDX_W'(i), extreme ? {$urandom(), $urandom()}
                                                          : {rand_f(), rand_f()});
        write_reg(REG_F22, {$urandom(), rand_f()});
        case ($urandom_range(3, 0))
            0: write_reg(REG_THRESH, {$urandom(), 32'hFFFF_FFFF});
            1: write_reg(REG_THRESH, 64'd1);
            default: write_reg(REG_THRESH, {32'd0, $urandom_range(32'h0100_0000, 1)});
        endcase
    endtask

    initial
    begin
        rst_n        = 1'b0;
        pts.valid    = 1'b0;
        pts.first_x  = '0; pts.first_y = '0; pts.first_z = '0;
        pts.second_x = '0; pts.second_y = '0; pts.second_z = '0;
        pts.start_of_set = 1'b0;
        res.ready    = 1'b0;
        cfg.valid    = 1'b0;
        cfg.index    = '0;
        cfg.data     = '0;
        err_count    = 0;
        hold_cycles  = 0;
        src_idle_pct = 37;
        snk_idle_pct = 56;
        for (int i = 0; i < 4; i++)
            fm_reg[i] = '0;
        f22_reg    = '0;
        thresh_reg = THRESH_RESET;
        score_acc  = '0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset matrix is all zero: every point degenerates
        add_pair('{32'h0001_0000, 0, 32'h0001_0000, 0, 0, 32'h0001_0000, 1'b1});
        drain_all();

        // essential-like matrix for a pure x translation, plus unused index
        write_reg(REG_F00_01, {32'd0, 32'd0});
        write_reg(REG_F02_10, {32'd0, 32'd0});
        write_reg(REG_F11_12, {32'hC000_0000, 32'd0});
        write_reg(REG_F20_21, {32'h4000_0000, 32'd0});
        write_reg(REG_F22, 64'hFFFF_FFFF_0000_0000);
        write_reg(REG_THRESH, 64'h0000_0000_0002_0000);
        write_reg(REG_NONE, 64'hDEAD_BEEF_DEAD_BEEF);
        add_pair('{32'h0001_0000, 32'h0002_0000, 32'h0001_0000,
                   32'h0003_0000, 32'h0002_0000, 32'h0001_0000, 1'b1});
        add_pair('{32'h0001_0000, 32'h0002_0000, 32'h0001_0000,
                   32'h0003_0000, 32'h0002_8000, 32'h0001_0000, 1'b0});
        add_pair('{32'h0001_0000, 32'h0002_0000, 32'h0000_0000,
                   32'h0003_0000, 32'h0002_0000, 32'h0001_0000, 1'b0});
        add_pair('{32'h0001_0000, 32'h0002_0000, 32'h0001_0000,
                   32'h0003_0000, 32'h0002_0000, 32'h0000_0000, 1'b0});
        add_pair('{32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001,
                   32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b0});
        add_pair('{32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                   32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0});
        add_pair('{32'hFFFF_0000, 32'h0000_8000, 32'hFFFF_0000,
                   32'h0000_4000, 32'h0100_0000, 32'h0001_0000, 1'b0});
        add_pair('{32'h0001_0000, 32'h0002_0000, 32'h0001_0000,
                   32'h0003_0000, 32'h0002_0100, 32'h0001_0000, 1'b1});
        drain_all();

        // extreme matrix, max threshold, and a long sink hold-off
        write_reg(REG_F00_01, 64'h7FFF_FFFF_8000_0000);
        write_reg(REG_F02_10, 64'h8000_0000_7FFF_FFFF);
        write_reg(REG_F11_12, 64'h7FFF_FFFF_7FFF_FFFF);
        write_reg(REG_F20_21, 64'h8000_0000_8000_0000);
        write_reg(REG_F22, 64'h7FFF_FFFF);
        write_reg(REG_THRESH, 64'hFFFF_FFFF);
        hold_cycles = 3000;
        for (int i = 0; i < 8; i++)
            add_pair(rand_pair(i));
        drain_all();

        for (int ph = 0; ph < 3; ph++)
        begin
            src_idle_pct = (ph == 0) ? 37 : (ph == 1) ? 56 : 0;
            snk_idle_pct = (ph == 0) ? 56 : (ph == 1) ? 37 : 0;
            for (int blk = 0; blk < 6; blk++)
            begin
                random_setting(blk == 5);
                for (int i = 0; i < 60; i++)
                    add_pair(rand_pair(i % 20));
                drain_all();
            end
        end

        if (err_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

`default_nettype wire
